// ----- rtl/dense_matrix_multiply_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the dense matrix multiply core
// Checks compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DENSE_MATRIX_MULTIPLY_CORE_DEFINES_SVH
`define DENSE_MATRIX_MULTIPLY_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent true implies consequent in the same cycle
`define DMM_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("dmm check failed");
// antecedent true implies consequent in the following cycle
`define DMM_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("dmm check failed");
`else
`define DMM_ASSERT_NOW(label, clock, reset, ante, cons)
`define DMM_ASSERT_NEXT(label, clock, reset, ante, cons)
`endif

`endif

// ----- rtl/dmm_pkg.sv -----
// ----------------------------------------------------------------------------
// dmm_pkg
// Types and constants for the dense matrix multiply core.
// ----------------------------------------------------------------------------
`default_nettype none

package dmm_pkg;

  localparam int IDX_W  = 3;
  localparam int DATA_W = 32;
  localparam int SIZE_W = 4;

  // request action codes
  typedef enum logic [1:0] {
    ACT_LOAD_LEFT  = 2'd0,
    ACT_LOAD_RIGHT = 2'd1,
    ACT_RUN        = 2'd2,
    ACT_NONE       = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]               action;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [DATA_W-1:0] product;
    logic                     last;
  } out_req_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/dense_matrix_multiply_core.sv -----
// ----------------------------------------------------------------------------
// dense_matrix_multiply_core
// Loads two square Q16.16 matrices into block RAM and streams out their
// product in row-major order, rounded to nearest and saturated to 32 bits.
// ----------------------------------------------------------------------------
//  channel  signals                       direction  carries
//  in       in_valid/in_ready/in_data     sink       load or run request
//  out      out_valid/out_ready/out_data  source     one product element
//  cfg      cfg_we/cfg_data               sink       matrix size (reset 8)
//
//  Load requests are accepted whenever the core is idle.
//  In a run, for n = effective size, each element needs n reads from
//  the two memories feeding one shared multiply-accumulate, then
//  pipeline drain, round and hand-off.
//  Requests are refused for the whole run; the output register lets the
//  next element be worked on while the previous one waits to be taken.
//  Reset is synchronous; the matrix memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dense_matrix_multiply_core_defines.svh"

module dense_matrix_multiply_core #(
  parameter int MAX_DIM = 8
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire dmm_pkg::in_req_t            in_data,
  output logic                             out_valid,
  input  wire                              out_ready,
  output dmm_pkg::out_req_t                out_data,
  input  wire                              cfg_we,
  input  wire [dmm_pkg::SIZE_W-1:0]        cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACC_W = 64 + $clog2(MAX_DIM);
  localparam int RND_W = ACC_W - 16;
  localparam logic [AW-1:0]              DIM_A   = AW'(MAX_DIM);
  localparam logic [dmm_pkg::SIZE_W-1:0] DIM_S   = dmm_pkg::SIZE_W'(MAX_DIM);
  localparam logic signed [ACC_W-1:0]    HALF_LSB = ACC_W'(32'sh8000);
  localparam logic signed [RND_W-1:0]    SAT_MAX = RND_W'(64'sh7FFF_FFFF);
  localparam logic signed [RND_W-1:0]    SAT_MIN = RND_W'(-64'sh8000_0000);

  dmm_pkg::state_t state, state_next;

  logic [dmm_pkg::SIZE_W-1:0] size;
  logic [dmm_pkg::IDX_W-1:0]  n_last;
  logic [dmm_pkg::IDX_W-1:0]  i_cnt, j_cnt, k_cnt;

  logic in_fire, run_start, load_left, load_right, in_range;
  logic issue, slot_free, emit_go, elem_last;

  logic [AW-1:0] wr_addr, rd_addr_left, rd_addr_right;

  logic [dmm_pkg::DATA_W-1:0] left_mem  [DEPTH];
  logic [dmm_pkg::DATA_W-1:0] right_mem [DEPTH];

  logic signed [dmm_pkg::DATA_W-1:0] rd_left, rd_right;
  logic signed [63:0]                prod;
  logic signed [ACC_W-1:0]           acc;
  logic signed [ACC_W-1:0]           acc_rnd;
  logic signed [RND_W-1:0]           rnd;
  logic signed [dmm_pkg::DATA_W-1:0] sat, result;

  logic v1, first1, lastk1;
  logic v2, first2, lastk2;
  logic acc_done;

  // request decode
  assign in_fire    = in_valid && in_ready;
  assign in_range   = ({1'b0, in_data.row} < DIM_S) && ({1'b0, in_data.col} < DIM_S);
  assign run_start  = in_fire && (in_data.action == dmm_pkg::ACT_RUN);
  assign load_left  = in_fire && (in_data.action == dmm_pkg::ACT_LOAD_LEFT) && in_range;
  assign load_right = in_fire && (in_data.action == dmm_pkg::ACT_LOAD_RIGHT) && in_range;

  assign slot_free = !out_valid || out_ready;
  assign elem_last = (i_cnt == n_last) && (j_cnt == n_last);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dmm_pkg::S_IDLE:  if (run_start) state_next = dmm_pkg::S_ISSUE;
      dmm_pkg::S_ISSUE: if (k_cnt == n_last) state_next = dmm_pkg::S_WAIT;
      dmm_pkg::S_WAIT:  if (acc_done) state_next = dmm_pkg::S_EMIT;
      dmm_pkg::S_EMIT: begin
        if (slot_free) state_next = elem_last ? dmm_pkg::S_IDLE : dmm_pkg::S_ISSUE;
      end
      default:          state_next = dmm_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    emit_go  = 1'b0;
    unique case (state)
      dmm_pkg::S_IDLE:  in_ready = 1'b1;
      dmm_pkg::S_ISSUE: issue    = 1'b1;
      dmm_pkg::S_WAIT:  ;
      dmm_pkg::S_EMIT:  emit_go  = slot_free;
      default:          ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // size register
  always_ff @(posedge clk) begin
    if (rst) begin
      size <= dmm_pkg::SIZE_W'(8);
    end else if (cfg_we) begin
      size <= cfg_data;
    end
  end

  // element counters
  always_ff @(posedge clk) begin
    if (rst) begin
      n_last <= '0;
      i_cnt  <= '0;
      j_cnt  <= '0;
      k_cnt  <= '0;
    end else begin
      if (run_start) begin
        if (size == '0) begin
          n_last <= '0;
        end else if (size > DIM_S) begin
          n_last <= dmm_pkg::IDX_W'(DIM_S - 1'b1);
        end else begin
          n_last <= dmm_pkg::IDX_W'(size - 1'b1);
        end
        i_cnt <= '0;
        j_cnt <= '0;
        k_cnt <= '0;
      end
      if (issue) begin
        k_cnt <= (k_cnt == n_last) ? '0 : k_cnt + 1'b1;
      end
      if (emit_go && !elem_last) begin
        if (j_cnt == n_last) begin
          j_cnt <= '0;
          i_cnt <= i_cnt + 1'b1;
        end else begin
          j_cnt <= j_cnt + 1'b1;
        end
      end
    end
  end

  // memory addressing: row * MAX_DIM + col
  assign wr_addr       = AW'(in_data.row) * DIM_A + AW'(in_data.col);
  assign rd_addr_left  = AW'(i_cnt) * DIM_A + AW'(k_cnt);
  assign rd_addr_right = AW'(k_cnt) * DIM_A + AW'(j_cnt);

  // matrix memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (load_left) begin
      left_mem[wr_addr] <= in_data.value;
    end
    if (load_right) begin
      right_mem[wr_addr] <= in_data.value;
    end
    rd_left  <= left_mem[rd_addr_left];
    rd_right <= right_mem[rd_addr_right];
  end

  // multiply-accumulate datapath
  always_ff @(posedge clk) begin
    prod <= rd_left * rd_right;
    if (v2) begin
      acc <= first2 ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
    if (acc_done) begin
      result <= sat;
    end
  end

  // pipeline tags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      first1   <= 1'b0;
      lastk1   <= 1'b0;
      v2       <= 1'b0;
      first2   <= 1'b0;
      lastk2   <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      v1       <= issue;
      first1   <= (k_cnt == '0);
      lastk1   <= (k_cnt == n_last);
      v2       <= v1;
      first2   <= first1;
      lastk2   <= lastk1;
      acc_done <= v2 && lastk2;
    end
  end

  // round to nearest, ties up, then saturate
  assign acc_rnd = acc + HALF_LSB;
  assign rnd     = RND_W'(acc_rnd >>> 16);
  always_comb begin
    if (rnd > SAT_MAX) begin
      sat = 32'sh7FFF_FFFF;
    end else if (rnd < SAT_MIN) begin
      sat = -32'sh8000_0000;
    end else begin
      sat = dmm_pkg::DATA_W'(rnd);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data.out_row <= i_cnt;
      out_data.out_col <= j_cnt;
      out_data.product <= result;
      out_data.last    <= elem_last;
    end
  end

  // checks
  `DMM_ASSERT_NOW(a_idle_empty, clk, rst, in_ready, !v1 && !v2 && !acc_done)
  `DMM_ASSERT_NOW(a_done_in_wait, clk, rst, acc_done, state == dmm_pkg::S_WAIT)
  `DMM_ASSERT_NOW(a_emit_drained, clk, rst, state == dmm_pkg::S_EMIT, !v1 && !v2)
  `DMM_ASSERT_NEXT(a_last_ends_run, clk, rst, emit_go && elem_last, state == dmm_pkg::S_IDLE)

endmodule

`default_nettype wire

// ----- sim/dense_matrix_multiply_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dense_matrix_multiply_core_tb
// Self-checking bench for the matrix multiply core. Loads matrix elements,
// runs multiplies at a range of sizes and checks every product element
// against a behavioural model, with random idling on both channels.
// ----------------------------------------------------------------------------

module dense_matrix_multiply_core_tb;

  localparam int DIM       = 8;
  localparam int SETTLE    = 16;
  localparam int MAX_CYC   = 1000000;
  localparam int ITEM_GOAL = 460;

  localparam logic signed [79:0] SAT_HI = 80'sd2147483647;
  localparam logic signed [79:0] SAT_LO = -80'sd2147483648;

  bit clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  dmm_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dmm_pkg::out_req_t out_data;
  logic cfg_we = 1'b0;
  logic [dmm_pkg::SIZE_W-1:0] cfg_data = '0;

  // model state
  logic signed [dmm_pkg::DATA_W-1:0] left_mat [0:DIM*DIM-1];
  logic signed [dmm_pkg::DATA_W-1:0] right_mat [0:DIM*DIM-1];
  logic [dmm_pkg::SIZE_W-1:0] dim_reg = 4'd8;
  dmm_pkg::out_req_t product_q[$];

  int fail_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;
  int sender_calm = 0;
  int stall_left = 0;
  int open_left = 0;

  dense_matrix_multiply_core #(.MAX_DIM(DIM)) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYC) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Behavioural model
  // ---------------------------------------------------------------------------

  function automatic int active_dim();
    if (dim_reg == 0) return 1;
    if (dim_reg > DIM) return DIM;
    return int'(dim_reg);
  endfunction

  // exact dot product, rounded half up to Q16.16, then saturated
  function automatic logic signed [dmm_pkg::DATA_W-1:0] dot_q16(int i, int j, int n);
    logic signed [79:0] acc;
    logic signed [79:0] rnd;
    logic signed [63:0] a64;
    logic signed [63:0] b64;
    acc = '0;
    for (int k = 0; k < n; k++) begin
      a64 = left_mat[i*DIM+k];
      b64 = right_mat[k*DIM+j];
      acc += a64 * b64;
    end
    rnd = (acc + 80'sd32768) >>> 16;
    if (rnd > SAT_HI) return 32'sh7FFFFFFF;
    if (rnd < SAT_LO) return 32'sh80000000;
    return rnd[dmm_pkg::DATA_W-1:0];
  endfunction

  task automatic model_request(input dmm_pkg::in_req_t r);
    int n;
    dmm_pkg::out_req_t e;
    case (dmm_pkg::action_t'(r.action))
      dmm_pkg::ACT_LOAD_LEFT:  left_mat[{r.row, r.col}] = r.value;
      dmm_pkg::ACT_LOAD_RIGHT: right_mat[{r.row, r.col}] = r.value;
      dmm_pkg::ACT_RUN: begin
        n = active_dim();
        for (int i = 0; i < n; i++) begin
          for (int j = 0; j < n; j++) begin
            e.out_row = i[dmm_pkg::IDX_W-1:0];
            e.out_col = j[dmm_pkg::IDX_W-1:0];
            e.product = dot_q16(i, j, n);
            e.last    = (i == n-1) && (j == n-1);
            product_q.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure and result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      if (stall_left == 0 && open_left == 0) begin
        stall_left = $urandom_range(1, 7);
        open_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        open_left--;
      end
    end
  end

  always @(posedge clk) begin
    dmm_pkg::out_req_t e;
    if (!rst && out_valid && out_ready) begin
      if (product_q.size() == 0) begin
        $error("unexpected product element row %0d col %0d",
               out_data.out_row, out_data.out_col);
        fail_count++;
      end else begin
        e = product_q.pop_front();
        if (out_data.out_row !== e.out_row) begin
          $error("out_row: expected %0d, actual %0d", e.out_row, out_data.out_row);
          fail_count++;
        end
        if (out_data.out_col !== e.out_col) begin
          $error("out_col: expected %0d, actual %0d", e.out_col, out_data.out_col);
          fail_count++;
        end
        if (out_data.product !== e.product) begin
          $error("product: expected %h, actual %h", e.product, out_data.product);
          fail_count++;
        end
        if (out_data.last !== e.last) begin
          $error("last: expected %0d, actual %0d", e.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side helpers
  // ---------------------------------------------------------------------------

  function automatic dmm_pkg::in_req_t make_req(dmm_pkg::action_t a, int r, int c,
                                                logic signed [dmm_pkg::DATA_W-1:0] v);
    dmm_pkg::in_req_t q;
    q.action = a;
    q.row    = r[dmm_pkg::IDX_W-1:0];
    q.col    = c[dmm_pkg::IDX_W-1:0];
    q.value  = v;
    return q;
  endfunction

  // mix of extremes, small Q16.16 numbers, mid-range and full random words
  function automatic logic signed [dmm_pkg::DATA_W-1:0] pick_value();
    int v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh7FFFFFFF;
          1: v = 32'sh80000000;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
      1, 2, 3: v = int'($urandom_range(0, 524288)) - 262144;
      4: v = int'($urandom_range(0, 33554432)) - 16777216;
      default: v = int'($urandom);
    endcase
    return v;
  endfunction

  // present one request and hold it until taken; valid is left high
  task automatic send_req(input dmm_pkg::in_req_t r);
    if (!quiet) begin
      if (sender_calm > 0) begin
        sender_calm--;
      end else if ($urandom_range(0, 5) == 0) begin
        sender_calm = $urandom_range(10, 40);
      end else if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    model_request(r);
    if (r.action != dmm_pkg::ACT_NONE) items_sent++;
  endtask

  // drop valid, wait for every product element, let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_size(input logic [dmm_pkg::SIZE_W-1:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dim_reg = v;
  endtask

  task automatic run_1x1(input logic signed [dmm_pkg::DATA_W-1:0] a,
                         input logic signed [dmm_pkg::DATA_W-1:0] b);
    send_req(make_req(dmm_pkg::ACT_LOAD_LEFT, 0, 0, a));
    send_req(make_req(dmm_pkg::ACT_LOAD_RIGHT, 0, 0, b));
    send_req(make_req(dmm_pkg::ACT_RUN, 0, 0, '0));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // single-element products: saturation both ways, rounding ties, size 0
  task automatic test_scalar_cases();
    write_size(4'd1);
    run_1x1(32'sh7FFFFFFF, 32'sh7FFFFFFF);
    run_1x1(32'sh80000000, 32'sh80000000);
    run_1x1(32'sh80000000, 32'sh7FFFFFFF);
    run_1x1(32'sh00000001, 32'sh00008000);   // tie, rounds up to 1
    run_1x1(32'shFFFFFFFF, 32'sh00008000);   // negative tie, rounds up to 0
    send_req(make_req(dmm_pkg::ACT_NONE, 7, 7, 32'sh7FFFFFFF));
    write_size(4'd0);                        // acts as size 1
    send_req(make_req(dmm_pkg::ACT_RUN, 7, 7, 32'sh80000000));
  endtask

  // fill both stores, then run at full size and above it
  task automatic test_full_size();
    write_size(4'd8);
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        send_req(make_req(dmm_pkg::ACT_LOAD_LEFT, r, c, pick_value()));
        send_req(make_req(dmm_pkg::ACT_LOAD_RIGHT, c, r, pick_value()));
      end
    end
    send_req(make_req(dmm_pkg::ACT_RUN, 0, 0, '0));
    write_size(4'd15);                       // clamps to full size
    send_req(make_req(dmm_pkg::ACT_RUN, 3, 5, 32'sh12345678));
  endtask

  // load bursts followed by a run, with size changes and some noise
  task automatic test_random_sequences();
    int n;
    int pick;
    int loads;
    while (items_sent < ITEM_GOAL - 60) begin
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) write_size(4'($urandom_range(1, 4)));
        else if (pick < 8) write_size(4'($urandom_range(5, 8)));
        else if (pick == 8) write_size(4'd0);
        else write_size(4'($urandom_range(9, 15)));
      end
      n = active_dim();
      loads = $urandom_range(0, 10);
      for (int k = 0; k < loads; k++) begin
        if ($urandom_range(0, 3) != 0)
          send_req(make_req($urandom_range(0, 1) ? dmm_pkg::ACT_LOAD_RIGHT
                                                 : dmm_pkg::ACT_LOAD_LEFT,
                            $urandom_range(0, n-1), $urandom_range(0, n-1),
                            pick_value()));
        else
          send_req(make_req($urandom_range(0, 1) ? dmm_pkg::ACT_LOAD_RIGHT
                                                 : dmm_pkg::ACT_LOAD_LEFT,
                            $urandom_range(0, 7), $urandom_range(0, 7),
                            pick_value()));
        if ($urandom_range(0, 7) == 0)
          send_req(make_req(dmm_pkg::ACT_NONE, $urandom_range(0, 7),
                            $urandom_range(0, 7), pick_value()));
      end
      // an occasional burst ends without a run
      if ($urandom_range(0, 9) != 0)
        send_req(make_req(dmm_pkg::ACT_RUN, $urandom_range(0, 7), $urandom_range(0, 7),
                          pick_value()));
    end
  endtask

  // closing stretch at full rate on both channels
  task automatic test_full_rate();
    drain();
    quiet = 1'b1;
    write_size(4'd8);
    for (int k = 0; k < 48; k++)
      send_req(make_req($urandom_range(0, 1) ? dmm_pkg::ACT_LOAD_RIGHT
                                             : dmm_pkg::ACT_LOAD_LEFT,
                        $urandom_range(0, 7), $urandom_range(0, 7), pick_value()));
    send_req(make_req(dmm_pkg::ACT_RUN, 0, 0, '0));
    send_req(make_req(dmm_pkg::ACT_LOAD_LEFT, 0, 0, pick_value()));
    send_req(make_req(dmm_pkg::ACT_RUN, 0, 0, '0));
    write_size(4'd1);
    send_req(make_req(dmm_pkg::ACT_RUN, 0, 0, '0));
    send_req(make_req(dmm_pkg::ACT_RUN, 0, 0, '0));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_scalar_cases();
    test_full_size();
    test_random_sequences();
    test_full_rate();

    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
